### sv/scfsa_pkg.sv
// Shared types, constants and the size-class lookup for the size class
// free stack allocator. No dependencies; the controller, datapath and top import this package.
package scfsa_pkg;

  localparam int STACK_DEPTH_DEF = 512;
  localparam int BIN_TOTAL_DEF   = 7;
  localparam int BIN_MAX         = 7;
  localparam int PAGE_BYTES      = 4096;
  localparam int PAGE_SHIFT      = 12;
  localparam int MIN_CHUNK_SHIFT = 5;
  localparam int ADDR_W          = 48;
  localparam int ENTRY_W         = ADDR_W - MIN_CHUNK_SHIFT;
  localparam int PAGE_CNT_W      = 21;
  localparam int BIN_W           = 3;
  localparam int GRANT_CNT_W     = 8;   // up to 128 chunks per page
  localparam int GRANT_IDX_W     = 7;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_GRANT = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    ST_ALLOCATED   = 4'd0,
    ST_ZERO        = 4'd1,
    ST_REFILL      = 4'd2,
    ST_LARGE_PAGES = 4'd3,
    ST_LARGE_BYTES = 4'd4,
    ST_FREED       = 4'd5,
    ST_FREE_LARGE  = 4'd6,
    ST_IGNORED     = 4'd7,
    ST_PAGE_OK     = 4'd8,
    ST_OVERFLOW    = 4'd9
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap_in;
    logic decode;
    logic capture;
    logic fill_step;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;
    logic need_fill;
    logic fill_last;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] idx;
  } class_hit_t;

  // Smallest class whose chunk size (32 << i) holds n bytes.
  function automatic class_hit_t class_of(input logic [31:0] n, input int bin_total);
    class_hit_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = BIN_MAX - 1; i >= 0; i--) begin
      if (i < bin_total && n <= (32'd32 << i)) begin
        r.hit = 1'b1;
        r.idx = BIN_W'(i);
      end
    end
    return r;
  endfunction

endpackage

### sv/scfsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module scfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/scfsa_ctrl.sv
// Controller state machine of the allocator: sequences accept, decode,
// stack read, page carving and result hand-off. Depends on scfsa_pkg.
module scfsa_ctrl import scfsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_FILL   = 5'b01000,
    S_WAIT   = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (stat.need_read) begin
          state_next = S_READ;
        end else if (stat.need_fill) begin
          state_next = S_FILL;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_next  = S_WAIT;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### sv/scfsa_dp.sv
// Datapath of the allocator: input and result registers, per-class fill
// counts, class decode and the chunk store. Depends on scfsa_pkg, scfsa_ram.
module scfsa_dp import scfsa_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int BIN_TOTAL   = BIN_TOTAL_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [1:0]            in_req_type,
  input  logic [31:0]           in_size,
  input  logic [31:0]           in_align,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic [BIN_W-1:0]      in_grant_bin,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [3:0]            out_status,
  output logic [ADDR_W-1:0]     out_chunk_address,
  output logic [BIN_W-1:0]      out_bin,
  output logic [PAGE_CNT_W-1:0] out_page_count
);

  localparam int MEM_DEPTH = BIN_TOTAL * STACK_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int FW        = $clog2(STACK_DEPTH + 1);

  // Captured request.
  logic [1:0]        req_type;
  logic [31:0]       size;
  logic [31:0]       align;
  logic [ADDR_W-1:0] address;
  logic [BIN_W-1:0]  grant_bin;

  // Result staging.
  logic [3:0]            res_status;
  logic [ADDR_W-1:0]     res_chunk;
  logic [BIN_W-1:0]      res_bin;
  logic [PAGE_CNT_W-1:0] res_pages;

  logic [FW-1:0] fill [BIN_MAX];

  // Page carving state.
  logic [BIN_W-1:0]       run_bin;
  logic [GRANT_IDX_W-1:0] run_idx;
  logic [GRANT_CNT_W-1:0] run_cnt;
  logic [ADDR_W-PAGE_SHIFT-1:0] run_page;

  // Decode.
  logic [31:0]            need;
  class_hit_t             alloc_cls, free_cls;
  logic [BIN_W-1:0]       sel_bin;
  logic [FW-1:0]          sel_fill;
  logic [GRANT_CNT_W-1:0] grant_cnt;
  logic                   grant_ok;
  logic [3:0]             dec_status;
  logic [BIN_W-1:0]       dec_bin;
  logic [PAGE_CNT_W-1:0]  dec_pages;
  logic                   dec_pop, dec_push, dec_fill;
  logic [32:0]            pages_sum;

  // Memory ports.
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [ENTRY_W-1:0]  wr_data, rd_data;
  logic [FW-1:0]       run_fill;

  always_comb begin
    need      = (size > align) ? size : align;
    alloc_cls = class_of(need, BIN_TOTAL);
    free_cls  = class_of(size, BIN_TOTAL);
    grant_cnt = GRANT_CNT_W'(128 >> grant_bin);
    pages_sum = 33'(size) + 33'(PAGE_BYTES - 1);
    grant_ok  = (32'(grant_bin) < 32'(BIN_TOTAL));

    sel_bin = grant_bin;
    case (req_type)
      REQ_ALLOC: sel_bin = alloc_cls.idx;
      REQ_FREE:  sel_bin = free_cls.idx;
      default:   sel_bin = grant_bin;
    endcase
    sel_fill = fill[sel_bin];

    dec_status = ST_IGNORED;
    dec_bin    = '0;
    dec_pages  = '0;
    dec_pop    = 1'b0;
    dec_push   = 1'b0;
    dec_fill   = 1'b0;
    unique case (req_type)
      REQ_ALLOC: begin
        if (size == '0) begin
          dec_status = ST_ZERO;
        end else if (alloc_cls.hit) begin
          dec_bin = sel_bin;
          if (sel_fill == '0) begin
            dec_status = ST_REFILL;
          end else begin
            dec_status = ST_ALLOCATED;
            dec_pop    = 1'b1;
          end
        end else if (align > 32'(PAGE_BYTES)) begin
          dec_status = ST_LARGE_PAGES;
          dec_pages  = pages_sum[32:PAGE_SHIFT];
        end else begin
          dec_status = ST_LARGE_BYTES;
        end
      end
      REQ_FREE: begin
        if (address != '0 && size != '0) begin
          if (!free_cls.hit) begin
            dec_status = ST_FREE_LARGE;
          end else begin
            dec_bin = sel_bin;
            if (sel_fill >= FW'(STACK_DEPTH)) begin
              dec_status = ST_OVERFLOW;
            end else begin
              dec_status = ST_FREED;
              dec_push   = 1'b1;
            end
          end
        end
      end
      REQ_GRANT: begin
        if (grant_ok) begin
          dec_bin = sel_bin;
          if ((FW + 1)'(sel_fill) + (FW + 1)'(grant_cnt) > (FW + 1)'(STACK_DEPTH)) begin
            dec_status = ST_OVERFLOW;
          end else begin
            dec_status = ST_PAGE_OK;
            dec_fill   = 1'b1;
          end
        end
      end
      default: begin
        dec_status = ST_IGNORED;
      end
    endcase
  end

  // Stack slot of class c at depth f is c * STACK_DEPTH + f.
  always_comb begin
    run_fill = fill[run_bin];
    rd_en    = cmd.decode && dec_pop;
    rd_addr  = AW'(32'(sel_bin) * STACK_DEPTH) + AW'(sel_fill - FW'(1));
    wr_en    = (cmd.decode && dec_push) || cmd.fill_step;
    if (cmd.fill_step) begin
      wr_addr = AW'(32'(run_bin) * STACK_DEPTH) + AW'(run_fill);
      wr_data = {run_page, GRANT_IDX_W'(run_idx << run_bin)};
    end else begin
      wr_addr = AW'(32'(sel_bin) * STACK_DEPTH) + AW'(sel_fill);
      wr_data = address[ADDR_W-1:MIN_CHUNK_SHIFT];
    end
  end

  always_comb begin
    stat.need_read = dec_pop;
    stat.need_fill = dec_fill;
    stat.fill_last = (GRANT_CNT_W'(run_idx) + GRANT_CNT_W'(1)) == run_cnt;
    stat.out_free  = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      req_type  <= in_req_type;
      size      <= in_size;
      align     <= in_align;
      address   <= in_address;
      grant_bin <= in_grant_bin;
    end
    if (cmd.decode) begin
      res_status <= dec_status;
      res_chunk  <= '0;
      res_bin    <= dec_bin;
      res_pages  <= dec_pages;
      run_bin    <= sel_bin;
      run_idx    <= '0;
      run_cnt    <= grant_cnt;
      run_page   <= address[ADDR_W-1:PAGE_SHIFT];
    end
    if (cmd.capture) begin
      res_chunk <= {rd_data, MIN_CHUNK_SHIFT'(0)};
    end
    if (cmd.fill_step) begin
      run_idx <= run_idx + GRANT_IDX_W'(1);
    end
    if (cmd.load_out) begin
      out_status        <= res_status;
      out_chunk_address <= res_chunk;
      out_bin           <= res_bin;
      out_page_count    <= res_pages;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < BIN_MAX; i++) begin
        fill[i] <= '0;
      end
    end else if (cmd.fill_step) begin
      fill[run_bin] <= run_fill + FW'(1);
    end else if (cmd.decode && dec_push) begin
      fill[sel_bin] <= sel_fill + FW'(1);
    end else if (cmd.decode && dec_pop) begin
      fill[sel_bin] <= sel_fill - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  scfsa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MEM_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // A carving write never goes past the top of its stack.
  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_step |-> run_fill < FW'(STACK_DEPTH))
    else $error("page carving writes beyond stack depth");

  // Read data is captured only in the cycle after a stack read was issued.
  a_capture_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> $past(rd_en))
    else $error("chunk captured without a preceding stack read");

  // A pop is only issued on a non-empty stack.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> sel_fill != '0)
    else $error("pop issued on an empty stack");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while full");

endmodule

### sv/size_class_free_stack_allocator_top.sv
// Top level of the size class free stack allocator: stream ports, the
// controller (scfsa_ctrl) and the datapath (scfsa_dp). Depends on scfsa_pkg.
//
//   Channel  Dir  Handshake          Carries
//   s_*      in   s_tvalid/s_tready  one request item (alloc, free, page grant)
//   m_*      out  m_tvalid/m_tready  one result item per request
//
// A request is registered on accept and decoded in the next cycle. Free,
// refill, large and ignored requests go to S_WAIT, a successful alloc first
// passes S_READ for the registered read of the chunk store, and an accepted
// page grant passes S_FILL, one chunk store write per carved chunk for
// (128 >> grant_bin) chunks. S_WAIT hands the result to the output register
// once it is free. The chunk store's single write port sets the grant time.
// Reset clears the per-class fill counts, so every stack starts empty; the
// chunk store itself needs no clearing pass.
// A new request is accepted while the previous result still waits in the
// output register; only a second finished result waits on m_tready.
module size_class_free_stack_allocator_top import scfsa_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int BIN_TOTAL   = BIN_TOTAL_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // s_tdata, low bit up: size[31:0], align[63:32], address[111:64],
  // grant_bin[114:112], zero pad[119:115].
  input  logic [119:0] s_tdata,
  // s_tuser: req_type[1:0].
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // m_tdata, low bit up: chunk_address[47:0], bin[50:48], page_count[71:51].
  output logic [71:0]  m_tdata,
  // m_tuser: status[3:0].
  output logic [3:0]   m_tuser
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  logic [ADDR_W-1:0]     chunk_address;
  logic [BIN_W-1:0]      bin;
  logic [PAGE_CNT_W-1:0] page_count;

  // The controller owns the sequencing; it sees only s_tvalid and datapath status.
  scfsa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // The datapath holds the fill counts, the chunk store and the result register.
  scfsa_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .BIN_TOTAL  (BIN_TOTAL)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (s_tuser),
    .in_size          (s_tdata[31:0]),
    .in_align         (s_tdata[63:32]),
    .in_address       (s_tdata[111:64]),
    .in_grant_bin     (s_tdata[114:112]),
    .m_tready         (m_tready),
    .m_tvalid         (m_tvalid),
    .out_status       (m_tuser),
    .out_chunk_address(chunk_address),
    .out_bin          (bin),
    .out_page_count   (page_count)
  );

  assign m_tdata = {page_count, bin, chunk_address};

endmodule
